/* hdl/rssw_pkg.sv */
package rssw_pkg;

  localparam int WINDOW_DEPTH_DEF = 32;
  localparam int FRAC_BITS_DEF    = 16;

  // Input action codes
  localparam logic [1:0] ACT_SEND = 2'd0;
  localparam logic [1:0] ACT_ACK  = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;
  localparam logic [1:0] ACT_IDLE = 2'd3;

  // Result event codes
  localparam logic [2:0] EV_SENT     = 3'd0;
  localparam logic [2:0] EV_NEW_ACK  = 3'd1;
  localparam logic [2:0] EV_DUP_ACK  = 3'd2;
  localparam logic [2:0] EV_FAST_RTX = 3'd3;
  localparam logic [2:0] EV_TIMEOUT  = 3'd4;
  localparam logic [2:0] EV_REJECTED = 3'd5;
  localparam logic [2:0] EV_NONE     = 3'd6;

  // Congestion phases
  localparam logic [1:0] PH_SLOW  = 2'd0;
  localparam logic [1:0] PH_AVOID = 2'd1;
  localparam logic [1:0] PH_RECOV = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_RWND  = 2'd0;
  localparam logic [1:0] REG_TIMEO = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;
  localparam logic [1:0] REG_ISEQ  = 2'd3;

  localparam logic [7:0] DUP_FIRE = 8'd3;
  localparam logic [7:0] DUP_MAX  = 8'd255;

endpackage

/* hdl/rssw_if.sv */
interface rssw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] segment_length;
  logic [31:0] ack_number;
  logic [31:0] sack_number;
  logic        checksum_ok;
  modport source (output valid, action, segment_length, ack_number, sack_number,
                  checksum_ok, input ready);
  modport sink (input valid, action, segment_length, ack_number, sack_number,
                checksum_ok, output ready);
endinterface

interface rssw_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [31:0] segment_seq;
  logic        retransmit;
  logic [5:0]  allowed_window;
  logic [5:0]  outstanding;
  logic [31:0] cwnd_out;
  logic [31:0] threshold_out;
  logic [1:0]  phase_out;
  logic [31:0] window_base;
  modport source (output valid, event_res, segment_seq, retransmit, allowed_window,
                  outstanding, cwnd_out, threshold_out, phase_out, window_base,
                  input ready);
  modport sink (input valid, event_res, segment_seq, retransmit, allowed_window,
                outstanding, cwnd_out, threshold_out, phase_out, window_base,
                output ready);
endinterface

/* hdl/rssw_ram.sv */
module rssw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/rssw_div.sv */
module rssw_div #(
  parameter int NW = 17,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);
  localparam int CNTW = $clog2(NW + 1);

  logic [DW-1:0]   rem;
  logic [CNTW-1:0] cnt;
  logic [DW:0]     trial;

  // Shift in the next dividend bit
  assign trial = {rem, quotient[NW-1]};

  // Restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem      <= '0;
        quotient <= dividend;
        cnt      <= CNTW'(NW);
      end else if (cnt != '0) begin
        if (trial >= {1'b0, divisor}) begin
          rem      <= DW'(trial - {1'b0, divisor});
          quotient <= {quotient[NW-2:0], 1'b1};
        end else begin
          rem      <= trial[DW-1:0];
          quotient <= {quotient[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* hdl/reno_sack_send_window_top.sv */
// Reno sender window with SACK marks. Transactions are taken one at a time
// under a sequencer; the input is not ready until the previous result has
// been loaded into the output register. A send, a tick with an empty window,
// an idle action or a corrupt ACK goes from accept straight to loading the
// result; a tick with held entries first reads and uses the head entry. A
// duplicate ACK passes through the ACK step; a fast retransmit with held
// entries adds the head read and use. A new ACK passes through the ACK step,
// the pop walk if entries are held and the window update, and in congestion
// avoidance waits on the restoring divider that forms 1/floor(cwnd). A
// non-zero SACK number visits each held entry, and the pop walk each entry
// examined (each popped entry, plus the first uncovered one if any remains).
// Window entries live in two RAMs with registered reads, so every entry
// visit takes a read step and a check step. A result that waits on a stalled
// output holds the block in its last step. A new input transaction is
// accepted while the previous result still waits on the output register.
module reno_sack_send_window_top
  import rssw_pkg::*;
#(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
  parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  rssw_in_if.sink     in_ch,
  rssw_out_if.source  out_ch,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [31:0] wr_data
);
  localparam int PW = WINDOW_DEPTH > 1 ? $clog2(WINDOW_DEPTH) : 1;
  localparam int PW1 = PW + 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int IW = 32 - FRAC_BITS;
  localparam int NW = FRAC_BITS + 1;
  localparam logic [32:0] ONE_Q = 33'(1) << FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_SACK_RD, S_SACK_CHK, S_ACK, S_POP_RD, S_POP_CHK,
    S_CWND, S_DIV, S_HEAD_RD, S_HEAD_USE, S_DONE
  } state_t;

  state_t state;

  logic [5:0]  rwnd;
  logic [31:0] timeo;
  logic [31:0] cwnd, thresh, snd_una, snd_nxt, time_now;
  logic [7:0]  dup_count;
  logic [1:0]  phase;
  logic [PW-1:0] head_ptr, walk_ptr;
  logic [CW-1:0] count, walk_i;

  logic [31:0] ack_r, sack_r;
  logic        is_tick;
  logic [2:0]  ev_r;
  logic [31:0] seq_r;
  logic        rtx_r;

  logic          a_we, b_we;
  logic [PW-1:0] a_waddr, b_waddr;
  logic [32:0]   a_wdata, a_rdata;
  logic [31:0]   b_wdata, b_rdata;

  logic          div_start, div_done;
  logic [NW-1:0] div_q;
  logic [IW-1:0] div_den;

  logic [31:0] allowed, win_int, halved;
  logic [32:0] cwnd_inc, cwnd_div, thr3;
  logic [39:0] thr_load;
  logic [PW:0]   tail_sum;
  logic [PW-1:0] tail_ptr;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (p == PW'(WINDOW_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  function automatic logic [31:0] sat32(input logic [32:0] v);
    return v[32] ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // Window and threshold arithmetic
  always_comb begin
    win_int = cwnd >> FRAC_BITS;
    allowed = win_int;
    if (allowed > {26'd0, rwnd}) begin
      allowed = {26'd0, rwnd};
    end
    if (allowed > 32'(WINDOW_DEPTH)) begin
      allowed = 32'(WINDOW_DEPTH);
    end
    halved = cwnd >> 1;
    if (halved < 32'(2 * ONE_Q)) begin
      halved = 32'(2 * ONE_Q);
    end
    cwnd_inc = {1'b0, cwnd} + ONE_Q;
    cwnd_div = {1'b0, cwnd} + 33'(div_q);
    thr3     = {1'b0, halved} + 33'(3) * ONE_Q;
    div_den  = (win_int[IW-1:0] == '0) ? IW'(1) : win_int[IW-1:0];
    thr_load = 40'(wr_data[15:0]) << FRAC_BITS;
    // Slot after the last held entry, wrapped at the window depth
    tail_sum = {1'b0, head_ptr} + PW1'(count);
    tail_ptr = (tail_sum >= PW1'(WINDOW_DEPTH)) ? PW'(tail_sum - PW1'(WINDOW_DEPTH))
                                                : tail_sum[PW-1:0];
  end

  assign in_ch.ready = (state == S_IDLE);
  assign div_start   = (state == S_CWND) && (phase == PH_AVOID);

  // Sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rwnd         <= 6'd32;
      timeo        <= 32'd500;
      cwnd         <= 32'(ONE_Q);
      thresh       <= 32'd16 << FRAC_BITS;
      dup_count    <= '0;
      phase        <= PH_SLOW;
      snd_una      <= 32'd1;
      snd_nxt      <= 32'd1;
      time_now     <= '0;
      head_ptr     <= '0;
      count        <= '0;
      a_we         <= 1'b0;
      b_we         <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      a_we <= 1'b0;
      b_we <= 1'b0;
      if (out_ch.valid && out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      // Configuration writes must arrive only while idle; the block does not enforce this
      if (wr_en) begin
        case (wr_index)
          REG_RWND:   rwnd  <= wr_data[5:0];
          REG_TIMEO:  timeo <= wr_data;
          REG_THRESH: thresh <= (thr_load[39:32] != '0) ? 32'hFFFF_FFFF : thr_load[31:0];
          REG_ISEQ: begin
            snd_una  <= wr_data;
            snd_nxt  <= wr_data;
            head_ptr <= '0;
            count    <= '0;
          end
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            ack_r   <= in_ch.ack_number;
            sack_r  <= in_ch.sack_number;
            ev_r    <= EV_NONE;
            seq_r   <= '0;
            rtx_r   <= 1'b0;
            is_tick <= 1'b0;
            walk_ptr <= head_ptr;
            walk_i   <= '0;
            state    <= S_DONE;
            if (in_ch.action == ACT_SEND) begin
              if (32'(count) >= allowed) begin
                ev_r <= EV_REJECTED;
              end else begin
                a_we     <= 1'b1;
                a_waddr  <= tail_ptr;
                a_wdata  <= {1'b0, snd_nxt};
                b_we     <= 1'b1;
                b_waddr  <= tail_ptr;
                b_wdata  <= time_now;
                count    <= count + 1'b1;
                seq_r    <= snd_nxt;
                snd_nxt  <= snd_nxt + 32'(in_ch.segment_length);
                ev_r     <= EV_SENT;
              end
            end else if (in_ch.action == ACT_ACK && in_ch.checksum_ok) begin
              if (in_ch.sack_number != '0 && count != '0) begin
                state <= S_SACK_RD;
              end else begin
                state <= S_ACK;
              end
            end else if (in_ch.action == ACT_TICK) begin
              time_now <= time_now + 1'b1;
              is_tick  <= 1'b1;
              if (count != '0) begin
                state <= S_HEAD_RD;
              end
            end
          end
        end
        S_SACK_RD: state <= S_SACK_CHK;
        S_SACK_CHK: begin
          // Mark the entry the SACK names
          if (a_rdata[31:0] == sack_r) begin
            a_we    <= 1'b1;
            a_waddr <= walk_ptr;
            a_wdata <= {1'b1, a_rdata[31:0]};
          end
          walk_ptr <= ptr_inc(walk_ptr);
          walk_i   <= walk_i + 1'b1;
          state    <= (walk_i + 1'b1 < count) ? S_SACK_RD : S_ACK;
        end
        S_ACK: begin
          if (ack_r > snd_una) begin
            snd_una   <= ack_r;
            dup_count <= '0;
            walk_ptr  <= head_ptr;
            ev_r      <= EV_NEW_ACK;
            state     <= (count != '0) ? S_POP_RD : S_CWND;
          end else begin
            state <= S_DONE;
            if (dup_count != DUP_MAX) begin
              dup_count <= dup_count + 1'b1;
            end
            if (dup_count + 1'b1 == DUP_FIRE) begin
              phase  <= PH_RECOV;
              thresh <= halved;
              cwnd   <= sat32(thr3);
              ev_r   <= EV_FAST_RTX;
              walk_ptr <= head_ptr;
              if (count != '0) begin
                state <= S_HEAD_RD;
              end
            end else begin
              if (phase == PH_RECOV) begin
                cwnd <= sat32(cwnd_inc);
              end
              ev_r <= EV_DUP_ACK;
            end
          end
        end
        S_POP_RD: state <= S_POP_CHK;
        S_POP_CHK: begin
          // Drop covered entries from the head
          if (a_rdata[31:0] < snd_una) begin
            head_ptr <= ptr_inc(head_ptr);
            walk_ptr <= ptr_inc(head_ptr);
            count    <= count - 1'b1;
            state    <= (count > CW'(1)) ? S_POP_RD : S_CWND;
          end else begin
            state <= S_CWND;
          end
        end
        S_CWND: begin
          state <= S_DONE;
          case (phase)
            PH_SLOW: begin
              cwnd <= sat32(cwnd_inc);
              if (sat32(cwnd_inc) >= thresh) begin
                phase <= PH_AVOID;
              end
            end
            PH_AVOID: state <= S_DIV;
            default: begin
              phase <= PH_AVOID;
              cwnd  <= thresh;
            end
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            cwnd  <= sat32(cwnd_div);
            state <= S_DONE;
          end
        end
        S_HEAD_RD: state <= S_HEAD_USE;
        S_HEAD_USE: begin
          state <= S_DONE;
          if (!is_tick) begin
            b_we    <= 1'b1;
            b_waddr <= head_ptr;
            b_wdata <= time_now;
            rtx_r   <= 1'b1;
            seq_r   <= a_rdata[31:0];
          end else if (!a_rdata[32] && (time_now - b_rdata) > timeo) begin
            thresh    <= halved;
            cwnd      <= 32'(ONE_Q);
            phase     <= PH_SLOW;
            dup_count <= '0;
            b_we      <= 1'b1;
            b_waddr   <= head_ptr;
            b_wdata   <= time_now;
            rtx_r     <= 1'b1;
            seq_r     <= a_rdata[31:0];
            ev_r      <= EV_TIMEOUT;
          end
        end
        S_DONE: begin
          // Load the output register once it is free
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid          <= 1'b1;
            out_ch.event_res      <= ev_r;
            out_ch.segment_seq    <= seq_r;
            out_ch.retransmit     <= rtx_r;
            out_ch.allowed_window <= allowed[5:0];
            out_ch.outstanding    <= 6'(count);
            out_ch.cwnd_out       <= cwnd;
            out_ch.threshold_out  <= thresh;
            out_ch.phase_out      <= phase;
            out_ch.window_base    <= snd_una;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  rssw_ram #(.WIDTH(33), .DEPTH(WINDOW_DEPTH)) u_seq_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(walk_ptr), .rdata(a_rdata)
  );

  rssw_ram #(.WIDTH(32), .DEPTH(WINDOW_DEPTH)) u_time_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(walk_ptr), .rdata(b_rdata)
  );

  rssw_div #(.NW(NW), .DW(IW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(NW'(ONE_Q)),
    .divisor(div_den), .done(div_done), .quotient(div_q)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= 32'(WINDOW_DEPTH))
    else $error("window holds more entries than its depth");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside the divide step");

  a_rtx_event: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.retransmit) |->
      (out_ch.event_res == EV_FAST_RTX || out_ch.event_res == EV_TIMEOUT))
    else $error("retransmit flagged without a retransmit event");

  a_time_write: assert property (@(posedge clk) disable iff (rst)
    b_we |-> ($past(state) == S_IDLE || $past(state) == S_HEAD_USE))
    else $error("send time written outside send or head update");

endmodule

/* verif/rssw_tb_if.sv */
`timescale 1ns / 1ps

// Channel bundles for the testbench live in the RTL interface file (hdl/rssw_if.sv);
// this file holds the shared result record used by the test top.
package rssw_tb_pkg;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [31:0] segment_seq;
    logic        retransmit;
    logic [5:0]  allowed_window;
    logic [5:0]  outstanding;
    logic [31:0] cwnd_out;
    logic [31:0] threshold_out;
    logic [1:0]  phase_out;
    logic [31:0] window_base;
  } window_result_t;

endpackage

/* verif/reno_sack_send_window_top_test.sv */
`timescale 1ns / 1ps

module reno_sack_send_window_top_test;
  import rssw_pkg::*;
  import rssw_tb_pkg::*;

  localparam int DEPTH = 32;
  localparam int FRAC = 16;
  localparam logic [31:0] ONE_Q = 32'h0001_0000;

  logic clk;
  logic rst;
  logic wr_en;
  logic [1:0] wr_index;
  logic [31:0] wr_data;

  rssw_in_if in_ch ();
  rssw_out_if out_ch ();

  reno_sack_send_window_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  // Predictor state: a shadow copy of the congestion state and send window
  logic [5:0]  rwnd_cfg;
  logic [31:0] timeout_cfg;
  logic [15:0] thresh_cfg;
  logic [31:0] cwnd, ssthresh, snd_una, snd_nxt, now_ticks;
  logic [7:0]  dup_acks;
  logic [1:0]  phase;
  logic [4:0]  head;
  logic [5:0]  held;
  logic [31:0] seg_seq [DEPTH];
  logic        seg_sacked [DEPTH];
  logic [31:0] seg_sent_at [DEPTH];

  window_result_t expected_results[$];
  int errors;
  int n_results;
  int ev_seen [8];
  bit no_idle;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] sat32(logic [32:0] v);
    return v[32] ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [5:0] window_allowed();
    logic [31:0] w;
    w = cwnd >> FRAC;
    if (w > {26'd0, rwnd_cfg}) w = {26'd0, rwnd_cfg};
    if (w > 32'(DEPTH)) w = 32'(DEPTH);
    return w[5:0];
  endfunction

  function automatic logic [31:0] halved_ssthresh();
    logic [31:0] h;
    h = cwnd >> 1;
    return (h > 2 * ONE_Q) ? h : 2 * ONE_Q;
  endfunction

  task automatic reset_window_model();
    rwnd_cfg = 6'd32;
    timeout_cfg = 32'd500;
    thresh_cfg = 16'd16;
    cwnd = ONE_Q;
    ssthresh = {16'd16, 16'd0};
    dup_acks = '0;
    phase = PH_SLOW;
    snd_una = 32'd1;
    snd_nxt = 32'd1;
    now_ticks = '0;
    head = '0;
    held = '0;
  endtask

  // Advance the shadow state by one transaction and queue what it should produce
  task automatic predict_window_step(logic [1:0] act, logic [15:0] len, logic [31:0] ack,
                                     logic [31:0] sack, logic ok);
    window_result_t r;
    logic [4:0] slot;
    logic [31:0] ip;
    r = '0;
    r.event_res = EV_NONE;
    if (act == ACT_SEND) begin
      if (held >= window_allowed()) begin
        r.event_res = EV_REJECTED;
      end else begin
        slot = head + held[4:0];
        seg_seq[slot] = snd_nxt;
        seg_sacked[slot] = 1'b0;
        seg_sent_at[slot] = now_ticks;
        held++;
        r.segment_seq = snd_nxt;
        snd_nxt += 32'(len);
        r.event_res = EV_SENT;
      end
    end else if (act == ACT_ACK && ok) begin
      if (sack != 0) begin
        for (int i = 0; i < held; i++) begin
          slot = head + i[4:0];
          if (seg_seq[slot] == sack) seg_sacked[slot] = 1'b1;
        end
      end
      if (ack > snd_una) begin
        snd_una = ack;
        while (held > 0 && seg_seq[head] < snd_una) begin
          head++;
          held--;
        end
        dup_acks = '0;
        if (phase == PH_SLOW) begin
          cwnd = sat32({1'b0, cwnd} + ONE_Q);
          if (cwnd >= ssthresh) phase = PH_AVOID;
        end else if (phase == PH_AVOID) begin
          ip = cwnd >> FRAC;
          if (ip == 0) ip = 32'd1;
          cwnd = sat32({1'b0, cwnd} + ONE_Q / ip);
        end else begin
          phase = PH_AVOID;
          cwnd = ssthresh;
        end
        r.event_res = EV_NEW_ACK;
      end else begin
        if (dup_acks < DUP_MAX) dup_acks++;
        if (dup_acks == DUP_FIRE) begin
          phase = PH_RECOV;
          ssthresh = halved_ssthresh();
          cwnd = sat32({1'b0, ssthresh} + 3 * ONE_Q);
          if (held > 0) begin
            seg_sent_at[head] = now_ticks;
            r.retransmit = 1'b1;
            r.segment_seq = seg_seq[head];
          end
          r.event_res = EV_FAST_RTX;
        end else begin
          if (phase == PH_RECOV) cwnd = sat32({1'b0, cwnd} + ONE_Q);
          r.event_res = EV_DUP_ACK;
        end
      end
    end else if (act == ACT_TICK) begin
      now_ticks++;
      if (held > 0 && !seg_sacked[head] && (now_ticks - seg_sent_at[head]) > timeout_cfg)
      begin
        ssthresh = halved_ssthresh();
        cwnd = ONE_Q;
        phase = PH_SLOW;
        dup_acks = '0;
        seg_sent_at[head] = now_ticks;
        r.retransmit = 1'b1;
        r.segment_seq = seg_seq[head];
        r.event_res = EV_TIMEOUT;
      end
    end
    r.allowed_window = window_allowed();
    r.outstanding = held;
    r.cwnd_out = cwnd;
    r.threshold_out = ssthresh;
    r.phase_out = phase;
    r.window_base = snd_una;
    expected_results = {expected_results, r};
  endtask

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99) < 16);
  endfunction

  // Offer one transaction, hold it until accepted, then predict
  task automatic send_item(logic [1:0] act, logic [15:0] len, logic [31:0] ack,
                           logic [31:0] sack, logic ok);
    while (idle_now()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.segment_length <= len;
    in_ch.ack_number <= ack;
    in_ch.sack_number <= sack;
    in_ch.checksum_ok <= ok;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_window_step(act, len, ack, sack, ok);
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    // Keep the input quiet before any register write
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_RWND: rwnd_cfg = val[5:0];
      REG_TIMEO: timeout_cfg = val;
      REG_THRESH: begin
        thresh_cfg = val[15:0];
        ssthresh = sat32({1'b0, thresh_cfg, 16'd0});
      end
      REG_ISEQ: begin
        snd_una = val;
        snd_nxt = val;
        head = '0;
        held = '0;
      end
      default: ;
    endcase
  endtask

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    window_result_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: event %0d", out_ch.event_res);
        errors++;
      end else begin
        e = expected_results.pop_front();
        n_results++;
        ev_seen[e.event_res]++;
        if (out_ch.event_res !== e.event_res) begin
          $error("event_res exp %0d got %0d", e.event_res, out_ch.event_res); errors++;
        end
        if (out_ch.segment_seq !== e.segment_seq) begin
          $error("segment_seq exp %h got %h", e.segment_seq, out_ch.segment_seq); errors++;
        end
        if (out_ch.retransmit !== e.retransmit) begin
          $error("retransmit exp %0d got %0d", e.retransmit, out_ch.retransmit); errors++;
        end
        if (out_ch.allowed_window !== e.allowed_window) begin
          $error("allowed_window exp %0d got %0d", e.allowed_window, out_ch.allowed_window);
          errors++;
        end
        if (out_ch.outstanding !== e.outstanding) begin
          $error("outstanding exp %0d got %0d", e.outstanding, out_ch.outstanding); errors++;
        end
        if (out_ch.cwnd_out !== e.cwnd_out) begin
          $error("cwnd_out exp %h got %h", e.cwnd_out, out_ch.cwnd_out); errors++;
        end
        if (out_ch.threshold_out !== e.threshold_out) begin
          $error("threshold_out exp %h got %h", e.threshold_out, out_ch.threshold_out);
          errors++;
        end
        if (out_ch.phase_out !== e.phase_out) begin
          $error("phase_out exp %0d got %0d", e.phase_out, out_ch.phase_out); errors++;
        end
        if (out_ch.window_base !== e.window_base) begin
          $error("window_base exp %h got %h", e.window_base, out_ch.window_base); errors++;
        end
      end
    end
  end

  // Receiver stalls at random
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= !idle_now();
  end

  // Pick an ACK number near the window so that pops and duplicates both occur
  function automatic logic [31:0] pick_ack();
    int k;
    k = $urandom_range(9);
    if (k < 3) return snd_una;
    if (k < 7 && held > 0)
      return seg_seq[5'(head + $urandom_range(held - 1))] + $urandom_range(1);
    if (k < 8) return snd_nxt;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_sack();
    if ($urandom_range(2) == 0) return 32'd0;
    if (held > 0 && $urandom_range(3) != 0)
      return seg_seq[5'(head + $urandom_range(held - 1))];
    return $urandom;
  endfunction

  task automatic test_directed_edges();
    send_item(ACT_SEND, 16'd0, 32'd0, 32'd0, 1'b0);
    send_item(ACT_SEND, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_item(ACT_ACK, 16'd0, 32'd2, 32'd1, 1'b0);
    send_item(ACT_ACK, 16'hFFFF, 32'd2, 32'd1, 1'b1);
    for (int i = 0; i < 4; i++) send_item(ACT_SEND, 16'd100, 32'd0, 32'd0, 1'b0);
    for (int i = 0; i < 5; i++) send_item(ACT_ACK, 16'd0, snd_una, 32'd0, 1'b1);
    send_item(ACT_ACK, 16'd0, snd_nxt, 32'd0, 1'b1);
    send_item(ACT_TICK, 16'd0, 32'd0, 32'd0, 1'b0);
    send_item(ACT_IDLE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    drain_results();
  endtask

  task automatic test_timeout_and_sack();
    write_reg(REG_TIMEO, 32'd1);
    for (int i = 0; i < 2; i++) send_item(ACT_SEND, 16'd10, 32'd0, 32'd0, 1'b0);
    send_item(ACT_ACK, 16'd0, snd_una, snd_una, 1'b1);
    for (int i = 0; i < 3; i++) send_item(ACT_TICK, 16'd0, 32'd0, 32'd0, 1'b0);
    send_item(ACT_ACK, 16'd0, snd_nxt, 32'd0, 1'b1);
    send_item(ACT_SEND, 16'd10, 32'd0, 32'd0, 1'b0);
    for (int i = 0; i < 4; i++) send_item(ACT_TICK, 16'd0, 32'd0, 32'd0, 1'b0);
    drain_results();
  endtask

  task automatic test_zero_window_and_wrap();
    write_reg(REG_RWND, 32'd0);
    send_item(ACT_SEND, 16'd5, 32'd0, 32'd0, 1'b0);
    drain_results();
    write_reg(REG_RWND, 32'd32);
    write_reg(REG_ISEQ, 32'hFFFF_FFF0);
    write_reg(REG_THRESH, 32'd2);
    send_item(ACT_SEND, 16'hFFFF, 32'd0, 32'd0, 1'b0);
    send_item(ACT_SEND, 16'd1, 32'd0, 32'd0, 1'b0);
    drain_results();
  endtask

  task automatic run_random_phase(int n_items);
    int k;
    for (int i = 0; i < n_items; i++) begin
      no_idle = (i > n_items / 2) && (i < n_items / 2 + 60);
      k = $urandom_range(99);
      if (k < 40) send_item(ACT_SEND,
                            ($urandom_range(3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(1500)),
                            $urandom, $urandom, 1'($urandom));
      else if (k < 85) send_item(ACT_ACK, 16'($urandom), pick_ack(), pick_sack(),
                                 $urandom_range(9) != 0);
      else if (k < 98) send_item(ACT_TICK, 16'($urandom), $urandom, $urandom, 1'($urandom));
      else send_item(ACT_IDLE, 16'($urandom), $urandom, $urandom, 1'($urandom));
    end
    no_idle = 1'b0;
    drain_results();
  endtask

  task automatic test_random_settings();
    run_random_phase(300);
    write_reg(REG_RWND, 32'd1);
    write_reg(REG_TIMEO, 32'hFFFF_FFFF);
    write_reg(REG_THRESH, 32'd65535);
    write_reg(REG_ISEQ, 32'd0);
    run_random_phase(300);
    write_reg(REG_RWND, 32'd32);
    write_reg(REG_TIMEO, 32'd3);
    write_reg(REG_THRESH, 32'd4);
    write_reg(REG_ISEQ, $urandom);
    run_random_phase(300);
    write_reg(REG_RWND, 32'd63);
    write_reg(REG_TIMEO, 32'd20);
    write_reg(REG_THRESH, 32'd8);
    run_random_phase(300);
    write_reg(REG_RWND, 32'd12);
    write_reg(REG_TIMEO, 32'd500);
    write_reg(REG_THRESH, 32'd16);
    write_reg(REG_ISEQ, 32'd1);
    run_random_phase(300);
  endtask

  initial begin
    errors = 0;
    n_results = 0;
    no_idle = 1'b0;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = REG_RWND;
    wr_data = '0;
    in_ch.valid = 1'b0;
    in_ch.action = ACT_SEND;
    in_ch.segment_length = '0;
    in_ch.ack_number = '0;
    in_ch.sack_number = '0;
    in_ch.checksum_ok = 1'b0;
    reset_window_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_edges();
    test_timeout_and_sack();
    test_zero_window_and_wrap();
    test_random_settings();
    $display("%0d results checked: sent %0d, new ack %0d, dup %0d, fast rtx %0d,",
             n_results, ev_seen[EV_SENT], ev_seen[EV_NEW_ACK], ev_seen[EV_DUP_ACK],
             ev_seen[EV_FAST_RTX]);
    $display("  timeout %0d, rejected %0d, dropped/idle %0d, across five register settings",
             ev_seen[EV_TIMEOUT], ev_seen[EV_REJECTED], ev_seen[EV_NONE]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("reno_sack_send_window_top: match");
    end else begin
      $display("reno_sack_send_window_top: mismatch");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #20ms;
    $display("reno_sack_send_window_top: mismatch");
    $finish;
  end

endmodule

/* reno_sack_send_window_top.f */
hdl/rssw_pkg.sv
hdl/rssw_if.sv
hdl/rssw_ram.sv
hdl/rssw_div.sv
hdl/reno_sack_send_window_top.sv
verif/rssw_tb_if.sv
verif/reno_sack_send_window_top_test.sv
